/* src/auto_contrast_stretch_assert.svh */
// assertion macros shared by the contrast stretch modules
`ifndef AUTO_CONTRAST_STRETCH_ASSERT_SVH
`define AUTO_CONTRAST_STRETCH_ASSERT_SVH

// implication checked on every clock, off during reset
`define ACS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// condition that holds on every clock out of reset
`define ACS_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

`endif

/* src/acs_pkg.sv */
// shared types and constants for the contrast stretch
package acs_pkg;
    localparam int unsigned LEVELS = 256;
    localparam int unsigned MAX_PIXELS_DEF = 4194304;
    localparam int unsigned LVL_W = 8;

    localparam logic [1:0] KIND_ACC = 2'd0;
    localparam logic [1:0] KIND_FIN = 2'd1;
    localparam logic [1:0] KIND_MAP = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam logic [1:0] REG_MODE = 2'd0;
    localparam logic [1:0] REG_LOW = 2'd1;
    localparam logic [1:0] REG_HIGH = 2'd2;
    localparam logic [1:0] REG_CLIP = 2'd3;

    localparam logic [7:0] DEF_LOW = 8'd1;
    localparam logic [7:0] DEF_HIGH = 8'd254;

    // controller to datapath
    typedef struct packed {
        logic       acc_rd;     // read bin for pixel
        logic       acc_wr;     // write bin back
        logic       map_rd;     // read table for pixel
        logic       cap_out;    // load output register from table data
        logic       fin_out;    // load output register with report
        logic       calc_t;     // compute threshold
        logic       scan_rd;    // read bin at scan index
        logic       scan_acc;   // accumulate and search
        logic       build_start;
        logic       build_step; // write one table entry
        logic       clear_step; // clear one bin
    } acs_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_last;
        logic build_last;
        logic div_busy;
        logic clear_last;
    } acs_sts_t;
endpackage

/* src/auto_contrast_stretch.sv */
// top level of the automatic contrast stretch
// Automatic contrast stretch for 8-bit grey pixels. An accumulate request
// reads its bin then writes it back, a map request reads the table then loads
// the output register; a new request is taken only once the last is done and
// the output register is free. A finish request walks the 256-bin histogram
// in automatic mode (manual mode skips it), rebuilds the 256-entry table with
// a one-bit-per-cycle divider for the entries between the levels, the others
// written without it, then clears the histogram before its report goes out.
// After reset a sweep writes the identity table and clears the histogram; no
// request is taken until then, configuration writes are taken at any time.
module auto_contrast_stretch #(
    parameter int unsigned MAX_PIXELS = acs_pkg::MAX_PIXELS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // pixel_in[7:0]
    input  logic [1:0]  s_axis_tuser,   // kind[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // pixel_out, low_level, high_level
    output logic        m_axis_tuser,   // result_kind
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    logic              mode_reg;
    logic [7:0]        mlow_reg, mhigh_reg;
    logic [15:0]       clip_reg;
    acs_pkg::acs_cmd_t cmd;
    acs_pkg::acs_sts_t sts;
    logic              ov;
    logic [24:0]       od;

    // configuration registers, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
            mlow_reg <= 8'd0;
            mhigh_reg <= 8'd255;
            clip_reg <= 16'd655;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                acs_pkg::REG_MODE: mode_reg <= cfg_data[0];
                acs_pkg::REG_LOW: mlow_reg <= cfg_data[7:0];
                acs_pkg::REG_HIGH: mhigh_reg <= cfg_data[7:0];
                acs_pkg::REG_CLIP: clip_reg <= cfg_data;
                default: mode_reg <= mode_reg;
            endcase
        end
    end

    acs_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(s_axis_tvalid), .in_kind(s_axis_tuser),
        .in_ready(s_axis_tready), .out_valid(ov), .out_ready(m_axis_tready),
        .manual_mode(mode_reg), .sts(sts), .cmd(cmd)
    );

    acs_datapath #(.MAX_PIXELS(MAX_PIXELS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .px(s_axis_tdata),
        .manual_mode(mode_reg), .manual_low(mlow_reg), .manual_high(mhigh_reg),
        .clip_q16(clip_reg), .out_ready(m_axis_tready), .out_valid(ov),
        .out_data(od)
    );

    assign m_axis_tvalid = ov;
    assign m_axis_tuser = od[0];
    assign m_axis_tdata = od[24:1];
endmodule

/* src/acs_ram.sv */
// generic single port write, single port read ram with registered read
module acs_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* src/acs_div.sv */
// restoring divider, one quotient bit per cycle
module acs_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [16:0] num,
    input  logic [9:0]  den,
    output logic        busy,
    output logic [16:0] quo
);
    logic [16:0] q_reg, q_next;
    logic [9:0]  r_reg, r_next;
    logic [9:0]  d_reg, d_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [10:0] trial;

    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        trial = {r_reg, q_reg[16]};
        if (start)
        begin
            q_next = num;
            r_next = '0;
            d_next = den;
            cnt_next = 5'd17;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_next = 10'(trial - {1'b0, d_reg});
                q_next = {q_reg[15:0], 1'b1};
            end
            else
            begin
                r_next = trial[9:0];
                q_next = {q_reg[15:0], 1'b0};
            end
            cnt_next = 5'(cnt_reg - 5'd1);
            busy_next = (cnt_reg != 5'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign busy = busy_reg;
    assign quo = q_reg;
endmodule

/* src/acs_datapath.sv */
// histogram, threshold search, table build and output register
`include "auto_contrast_stretch_assert.svh"
module acs_datapath #(
    parameter int unsigned MAX_PIXELS = acs_pkg::MAX_PIXELS_DEF,
    parameter int unsigned CNT_W = $clog2(MAX_PIXELS + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  acs_pkg::acs_cmd_t cmd,
    output acs_pkg::acs_sts_t sts,
    input  logic [7:0]        px,
    input  logic              manual_mode,
    input  logic [7:0]        manual_low,
    input  logic [7:0]        manual_high,
    input  logic [15:0]       clip_q16,
    input  logic              out_ready,
    output logic              out_valid,
    output logic [24:0]       out_data
);
    localparam logic [CNT_W-1:0] MAXC = CNT_W'(MAX_PIXELS);
    // running sum over 256 saturated bins
    localparam int unsigned CUM_W = CNT_W + 8;

    // histogram memory, cleared by a sweep after each finish and after reset
    logic              h_we;
    logic [7:0]        h_waddr, h_raddr;
    logic [CNT_W-1:0]  h_wdata, h_rdata;

    acs_ram #(.WIDTH(CNT_W), .DEPTH(acs_pkg::LEVELS)) u_hist (
        .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
        .raddr(h_raddr), .rdata(h_rdata)
    );

    // stretch table memory, identity written by the reset sweep
    logic       t_we;
    logic [7:0] t_waddr, t_wdata, t_raddr, t_rdata;

    acs_ram #(.WIDTH(8), .DEPTH(acs_pkg::LEVELS)) u_tab (
        .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
        .raddr(t_raddr), .rdata(t_rdata)
    );

    logic [7:0]        apx_reg;
    logic [CNT_W-1:0]  total_reg, total_next;
    logic [CNT_W-1:0]  t_reg, upper_reg;
    logic [CUM_W-1:0]  cum_reg, cum_next;
    logic [8:0]        idx_reg, idx_next;
    logic [7:0]        lo_reg, hi_reg, lo_next, hi_next;
    logic              lo_found_reg, lo_found_next;
    logic [7:0]        black_reg, white_reg;
    logic              init_reg;
    logic              ov_reg;
    logic [24:0]       od_reg;
    logic [CNT_W+16:0] prod;
    logic [CNT_W+16:0] tq;
    logic [CUM_W-1:0]  cum_sum;
    logic [7:0]        scan_i;
    logic [CNT_W-1:0]  binc;
    logic [7:0]        bi;
    logic [8:0]        span;
    logic              div_busy;
    logic [16:0]       quo;
    logic              div_start;
    logic              div_wait_reg;
    logic [7:0]        build_val;

    assign prod = (CNT_W+17)'(total_reg) * (CNT_W+17)'(clip_q16);
    assign tq = (prod + (CNT_W+17)'(32768)) >> 16;
    assign binc = (h_rdata >= MAXC) ? MAXC : CNT_W'(h_rdata + CNT_W'(1));
    assign scan_i = 8'(idx_reg - 9'd1);
    assign cum_sum = cum_reg + CUM_W'(h_rdata);
    assign bi = idx_reg[7:0];
    assign span = {1'b0, white_reg} - {1'b0, black_reg};

    acs_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .num(17'({9'd0, 8'(bi - black_reg)} * 17'd510 + 17'(span))),
        .den({span, 1'b0}), .busy(div_busy), .quo(quo)
    );

    always_comb
    begin
        build_val = 8'd255;
        if (bi <= black_reg)
        begin
            build_val = 8'd0;
        end
        else if (bi < white_reg)
        begin
            build_val = (quo > 17'd255) ? 8'd255 : quo[7:0];
        end
    end

    // interior entries need a divide, others write at once; the reset sweep never divides
    assign div_start = cmd.build_step && !init_reg && (bi > black_reg) && (bi < white_reg)
                       && !div_wait_reg;

    always_comb
    begin
        h_we = 1'b0;
        h_waddr = apx_reg;
        h_wdata = binc;
        h_raddr = px;
        if (cmd.acc_wr)
        begin
            h_we = 1'b1;
        end
        if (cmd.clear_step)
        begin
            h_we = 1'b1;
            h_waddr = idx_reg[7:0];
            h_wdata = '0;
        end
        if (cmd.scan_rd)
        begin
            h_raddr = idx_reg[7:0];
        end
        t_we = 1'b0;
        t_waddr = bi;
        t_wdata = init_reg ? bi : build_val;
        t_raddr = px;
        if (cmd.build_step && (init_reg || !div_start) && !div_busy)
        begin
            t_we = 1'b1;
        end
    end

    always_comb
    begin
        total_next = total_reg;
        cum_next = cum_reg;
        idx_next = idx_reg;
        lo_next = lo_reg;
        hi_next = hi_reg;
        lo_found_next = lo_found_reg;
        if (cmd.acc_rd)
        begin
            total_next = (total_reg >= MAXC) ? MAXC : CNT_W'(total_reg + CNT_W'(1));
        end
        if (cmd.calc_t)
        begin
            cum_next = '0;
            idx_next = '0;
            lo_next = acs_pkg::DEF_LOW;
            hi_next = acs_pkg::DEF_HIGH;
            lo_found_next = 1'b0;
        end
        if (cmd.scan_rd)
        begin
            idx_next = 9'(idx_reg + 9'd1);
        end
        if (cmd.scan_acc)
        begin
            cum_next = cum_sum;
            if (!lo_found_next && (cum_sum > CUM_W'(t_reg)))
            begin
                lo_next = scan_i;
                lo_found_next = 1'b1;
            end
            if (cum_sum < CUM_W'(upper_reg))
            begin
                hi_next = scan_i;
            end
        end
        if (cmd.build_start)
        begin
            idx_next = '0;
        end
        if (t_we || cmd.clear_step)
        begin
            idx_next = 9'(idx_reg + 9'd1);
        end
        if (cmd.fin_out)
        begin
            total_next = '0;
            idx_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            idx_reg <= '0;
            black_reg <= 8'd0;
            white_reg <= 8'd255;
            init_reg <= 1'b1;
            ov_reg <= 1'b0;
            lo_found_reg <= 1'b0;
            div_wait_reg <= 1'b0;
        end
        else
        begin
            total_reg <= total_next;
            idx_reg <= idx_next;
            lo_found_reg <= lo_found_next;
            // levels include the last bin searched in this same cycle
            if (cmd.build_start)
            begin
                black_reg <= manual_mode ? manual_low : lo_next;
                white_reg <= manual_mode ? manual_high : hi_next;
            end
            if (sts.build_last)
            begin
                init_reg <= 1'b0;
            end
            if (div_start)
            begin
                div_wait_reg <= 1'b1;
            end
            else if (t_we)
            begin
                div_wait_reg <= 1'b0;
            end
            if (cmd.cap_out || cmd.fin_out)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cum_reg <= cum_next;
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        if (cmd.acc_rd)
        begin
            apx_reg <= px;
        end
        if (cmd.calc_t)
        begin
            t_reg <= (tq > (CNT_W+17)'(total_reg)) ? total_reg : CNT_W'(tq);
            upper_reg <= (tq > (CNT_W+17)'(total_reg)) ? '0
                         : CNT_W'((CNT_W+17)'(total_reg) - tq);
        end
        if (cmd.cap_out)
        begin
            od_reg <= {white_reg, black_reg, t_rdata, 1'b0};
        end
        else if (cmd.fin_out)
        begin
            od_reg <= {white_reg, black_reg, 8'd0, 1'b1};
        end
    end

    assign sts.scan_last = (idx_reg == 9'd256);
    assign sts.build_last = t_we && (bi == 8'd255);
    assign sts.div_busy = div_busy || div_start;
    assign sts.clear_last = cmd.clear_step && (idx_reg[7:0] == 8'd255);
    assign out_valid = ov_reg;
    assign out_data = od_reg;

    `ACS_ASSERT_IMPL(a_total_sat, clk, rst_n, 1'b1, total_reg <= MAXC)
    `ACS_ASSERT_IMPL(a_no_clash, clk, rst_n, cmd.acc_wr, !cmd.clear_step)
    `ACS_ASSERT_IMPL(a_out_hold, clk, rst_n, out_valid && !out_ready,
                     !(cmd.cap_out || cmd.fin_out))
endmodule

/* src/acs_ctrl.sv */
// sequencer for accumulate, map, finish scan, table build and clear
`include "auto_contrast_stretch_assert.svh"
module acs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [1:0]        in_kind,
    output logic              in_ready,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic              manual_mode,
    input  acs_pkg::acs_sts_t sts,
    output acs_pkg::acs_cmd_t cmd
);
    typedef enum logic [8:0] {
        S_INIT   = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_ACC    = 9'b000000100,
        S_MAP    = 9'b000001000,
        S_THR    = 9'b000010000,
        S_SCAN   = 9'b000100000,
        S_BUILD  = 9'b001000000,
        S_CLEAR  = 9'b010000000,
        S_REPORT = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   obusy;
    logic   take;

    // output register still held this cycle
    assign obusy = out_valid && !out_ready;
    assign in_ready = (state_reg == S_IDLE) && !obusy;
    assign take = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            S_INIT:
            begin
                cmd.build_step = 1'b1;
                cmd.clear_step = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (take)
                begin
                    case (in_kind)
                        acs_pkg::KIND_ACC:
                        begin
                            cmd.acc_rd = 1'b1;
                            state_next = S_ACC;
                        end
                        acs_pkg::KIND_MAP:
                        begin
                            cmd.map_rd = 1'b1;
                            state_next = S_MAP;
                        end
                        acs_pkg::KIND_FIN:
                        begin
                            cmd.calc_t = 1'b1;
                            state_next = manual_mode ? S_BUILD : S_THR;
                            if (manual_mode)
                            begin
                                cmd.build_start = 1'b1;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_ACC:
            begin
                cmd.acc_wr = 1'b1;
                state_next = S_IDLE;
            end
            S_MAP:
            begin
                cmd.cap_out = 1'b1;
                state_next = S_IDLE;
            end
            S_THR:
            begin
                cmd.scan_rd = 1'b1;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan_acc = 1'b1;
                if (sts.scan_last)
                begin
                    cmd.build_start = 1'b1;
                    state_next = S_BUILD;
                end
                else
                begin
                    cmd.scan_rd = 1'b1;
                end
            end
            S_BUILD:
            begin
                cmd.build_step = 1'b1;
                if (sts.build_last)
                begin
                    state_next = S_CLEAR;
                end
            end
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = S_REPORT;
                end
            end
            S_REPORT:
            begin
                if (!obusy)
                begin
                    cmd.fin_out = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `ACS_ASSERT_IMPL(a_ready_idle, clk, rst_n, in_ready, state_reg == S_IDLE)
    `ACS_ASSERT_ALWAYS(a_onehot, clk, rst_n, $onehot(state_reg))
    `ACS_ASSERT_IMPL(a_map_out, clk, rst_n, state_reg == S_MAP, !obusy)
endmodule

/* dv/tb_auto_contrast_stretch.sv */
// testbench for the automatic contrast stretch: histogram, percentile levels and mapping
`timescale 1ns / 1ps

module tb_auto_contrast_stretch;
    localparam int unsigned PIXEL_CAP = acs_pkg::MAX_PIXELS_DEF;
    localparam int unsigned IDLE_LIMIT = 20000;

    typedef struct packed {
        logic       rkind;
        logic [7:0] pix;
        logic [7:0] lo;
        logic [7:0] hi;
    } stretch_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    // predictor state
    logic        pred_manual;
    logic [7:0]  pred_man_low;
    logic [7:0]  pred_man_high;
    logic [15:0] pred_clip;
    int unsigned hist_bins [acs_pkg::LEVELS];
    int unsigned hist_total;
    logic [7:0]  lut [acs_pkg::LEVELS];
    logic [7:0]  cur_low;
    logic [7:0]  cur_high;

    stretch_result_t expected_results [$];
    int          fail_count = 0;
    int          idle_cycles = 0;
    bit          sink_hold = 1'b0;
    bit          sink_busy = 1'b1;

    always #4 clk = ~clk;

    auto_contrast_stretch uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // rebuild the lookup from a black and a white level
    function automatic void rebuild_lut(input int unsigned lo, input int unsigned hi);
        int unsigned span;
        int unsigned v;
        for (int unsigned i = 0; i < acs_pkg::LEVELS; i++)
        begin
            if (i <= lo)
                lut[i] = 8'd0;
            else if (i < hi)
            begin
                span = hi - lo;
                v = (2 * (i - lo) * 255 + span) / (2 * span);
                lut[i] = (v > 255) ? 8'd255 : v[7:0];
            end
            else
                lut[i] = 8'd255;
        end
        cur_low = lo[7:0];
        cur_high = hi[7:0];
    endfunction

    // percentile search in automatic mode, then table rebuild and histogram clear
    function automatic void close_frame();
        int unsigned lo;
        int unsigned hi;
        longint unsigned thr;
        longint unsigned upper;
        longint unsigned cum [acs_pkg::LEVELS];
        longint unsigned acc;
        lo = acs_pkg::DEF_LOW;
        hi = acs_pkg::DEF_HIGH;
        if (pred_manual)
        begin
            lo = pred_man_low;
            hi = pred_man_high;
        end
        else
        begin
            thr = (longint'(hist_total) * pred_clip + 32768) >> 16;
            upper = (thr <= hist_total) ? hist_total - thr : 0;
            acc = 0;
            for (int i = 0; i < acs_pkg::LEVELS; i++)
            begin
                acc += hist_bins[i];
                cum[i] = acc;
            end
            for (int i = 0; i < acs_pkg::LEVELS; i++)
                if (cum[i] > thr)
                begin
                    lo = i;
                    break;
                end
            for (int i = acs_pkg::LEVELS - 1; i >= 0; i--)
                if (cum[i] < upper)
                begin
                    hi = i;
                    break;
                end
        end
        rebuild_lut(lo, hi);
        foreach (hist_bins[i])
            hist_bins[i] = 0;
        hist_total = 0;
    endfunction

    function automatic void predict_request(input logic [1:0] kind, input logic [7:0] px);
        stretch_result_t r;
        case (kind)
            acs_pkg::KIND_ACC:
            begin
                if (hist_bins[px] < PIXEL_CAP)
                    hist_bins[px]++;
                if (hist_total < PIXEL_CAP)
                    hist_total++;
            end
            acs_pkg::KIND_FIN:
            begin
                close_frame();
                r = '{1'b1, 8'd0, cur_low, cur_high};
                expected_results.push_back(r);
            end
            acs_pkg::KIND_MAP:
            begin
                r = '{1'b0, lut[px], cur_low, cur_high};
                expected_results.push_back(r);
            end
            default: ;
        endcase
    endfunction

    // one request on the input stream, with a random gap first
    task automatic send_request(input logic [1:0] kind, input logic [7:0] px);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        // valid stays up into a back to back request
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= px;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_request(kind, px);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        // a trailing accumulate may still be in flight
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            acs_pkg::REG_MODE: pred_manual = val[0];
            acs_pkg::REG_LOW:  pred_man_low = val[7:0];
            acs_pkg::REG_HIGH: pred_man_high = val[7:0];
            acs_pkg::REG_CLIP: pred_clip = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_stretch(input logic mode, input logic [7:0] lo, input logic [7:0] hi,
                               input logic [15:0] clip);
        wait_drained();
        write_reg(acs_pkg::REG_MODE, {15'd0, mode});
        write_reg(acs_pkg::REG_LOW, {8'd0, lo});
        write_reg(acs_pkg::REG_HIGH, {8'd0, hi});
        write_reg(acs_pkg::REG_CLIP, clip);
    endtask

    // a frame of random pixels spread around a center, with stray maps and unused requests, then finish and some maps
    task automatic run_frame(input int npix, input int nmap);
        int center;
        int spread;
        int v;
        center = $urandom_range(0, 255);
        spread = $urandom_range(0, 128);
        for (int i = 0; i < npix; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                send_request(acs_pkg::KIND_UNUSED, 8'($urandom));
            v = center + $signed($urandom_range(0, 2 * spread)) - spread;
            v = (v < 0) ? 0 : (v > 255) ? 255 : v;
            send_request(($urandom_range(0, 15) == 0) ? acs_pkg::KIND_MAP : acs_pkg::KIND_ACC,
                         v[7:0]);
        end
        send_request(acs_pkg::KIND_FIN, 8'($urandom));
        for (int i = 0; i < nmap; i++)
            send_request(acs_pkg::KIND_MAP, 8'($urandom));
    endtask

    task automatic test_reset_identity();
        send_request(acs_pkg::KIND_MAP, 8'd0);
        send_request(acs_pkg::KIND_MAP, 8'd255);
        send_request(acs_pkg::KIND_MAP, 8'd128);
        send_request(acs_pkg::KIND_UNUSED, 8'hFF);
    endtask

    task automatic test_empty_frame();
        send_request(acs_pkg::KIND_FIN, 8'hA5);
        send_request(acs_pkg::KIND_MAP, 8'd0);
        send_request(acs_pkg::KIND_MAP, 8'd1);
        send_request(acs_pkg::KIND_MAP, 8'd2);
        send_request(acs_pkg::KIND_MAP, 8'd254);
        send_request(acs_pkg::KIND_MAP, 8'd255);
    endtask

    task automatic test_extreme_pixels();
        send_request(acs_pkg::KIND_ACC, 8'd0);
        send_request(acs_pkg::KIND_ACC, 8'd255);
        send_request(acs_pkg::KIND_ACC, 8'd0);
        send_request(acs_pkg::KIND_ACC, 8'd255);
        send_request(acs_pkg::KIND_FIN, 8'd0);
        send_request(acs_pkg::KIND_MAP, 8'd127);
    endtask

    task automatic test_manual_levels();
        // crossed levels, no division
        set_stretch(1'b1, 8'd200, 8'd50, 16'd0);
        send_request(acs_pkg::KIND_ACC, 8'd10);
        send_request(acs_pkg::KIND_FIN, 8'd0);
        send_request(acs_pkg::KIND_MAP, 8'd200);
        send_request(acs_pkg::KIND_MAP, 8'd201);
        set_stretch(1'b1, 8'd0, 8'd255, 16'hFFFF);
        send_request(acs_pkg::KIND_FIN, 8'd0);
        send_request(acs_pkg::KIND_MAP, 8'd170);
        // automatic finish, which shows that the manual finishes cleared the histogram
        set_stretch(1'b0, 8'd255, 8'd0, 16'd0);
        send_request(acs_pkg::KIND_FIN, 8'd0);
    endtask

    task automatic test_random_frames();
        logic [15:0] clips [4];
        clips = '{16'd0, 16'd655, 16'd8000, 16'hFFFF};
        for (int f = 0; f < 28; f++)
        begin
            if (f % 4 == 0)
                set_stretch($urandom_range(0, 3) == 0, 8'($urandom), 8'($urandom),
                            ($urandom_range(0, 1) == 0) ? clips[$urandom_range(0, 3)]
                                                         : 16'($urandom));
            run_frame($urandom_range(8, 60), $urandom_range(4, 12));
        end
    endtask

    task automatic test_output_backpressure();
        sink_hold = 1'b1;
        fork
            begin
                repeat (300) @(posedge clk);
                sink_hold = 1'b0;
            end
            for (int i = 0; i < 40; i++)
                send_request(acs_pkg::KIND_MAP, 8'($urandom));
        join
        // sender pauses until the block has drained
        wait_drained();
        run_frame(30, 20);
    endtask

    // result checker with random stalls
    always @(posedge clk)
    begin
        stretch_result_t got;
        stretch_result_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[23:16]};
            if (expected_results.size() == 0)
            begin
                $error("unexpected result %h", got);
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.rkind !== want.rkind)
                begin
                    $error("result_kind: expected %0d actual %0d", want.rkind, got.rkind);
                    fail_count++;
                end
                if (got.pix !== want.pix)
                begin
                    $error("pixel_out: expected %0d actual %0d", want.pix, got.pix);
                    fail_count++;
                end
                if (got.lo !== want.lo)
                begin
                    $error("low_level: expected %0d actual %0d", want.lo, got.lo);
                    fail_count++;
                end
                if (got.hi !== want.hi)
                begin
                    $error("high_level: expected %0d actual %0d", want.hi, got.hi);
                    fail_count++;
                end
            end
        end
        if (sink_hold)
            m_axis_tready <= 1'b0;
        else if (!sink_busy)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(0, 3) != 0);
    end

    // stall pattern changes now and then, with stretches of none
    always @(posedge clk)
        if ($urandom_range(0, 199) == 0)
            sink_busy <= ~sink_busy;

    // watchdog on cycles with no handshake on the input, output or configuration port
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("** auto_contrast_stretch: FAILED **");
            $finish;
        end
    end

    initial
    begin
        pred_manual = 1'b0;
        pred_man_low = 8'd0;
        pred_man_high = 8'd255;
        pred_clip = 16'd655;
        foreach (hist_bins[i])
            hist_bins[i] = 0;
        hist_total = 0;
        rebuild_lut(0, 255);
        for (int i = 0; i < acs_pkg::LEVELS; i++)
            lut[i] = i[7:0];
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_identity();
        test_empty_frame();
        test_extreme_pixels();
        test_manual_levels();
        test_random_frames();
        test_output_backpressure();
        wait_drained();
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("** auto_contrast_stretch: PASSED **");
        else
            $display("** auto_contrast_stretch: FAILED **");
        $finish;
    end
endmodule

/* files.f */
+incdir+src
src/acs_pkg.sv
src/acs_ram.sv
src/acs_div.sv
src/acs_datapath.sv
src/acs_ctrl.sv
src/auto_contrast_stretch.sv
dv/tb_auto_contrast_stretch.sv
